>>> hw/rtl/fatcw_pkg.sv
`timescale 1ns / 1ps

package fatcw_pkg;

  localparam int FAT_BYTES = 8192;
  localparam int FAT_AW    = $clog2(FAT_BYTES);

  localparam int SEC_W   = 25;
  localparam int CLUS_W  = 12;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 3;
  localparam int PROD_W  = 24;

  // root directory division: numerator up to 65535*32 + 8190
  localparam int DIV_NUM_W = 22;
  localparam int DIV_DEN_W = 13;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [CLUS_W-1:0] CHAIN_END = 12'hFF8;
  localparam logic [CLUS_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

  localparam logic [12:0] RST_BYTES_PER_SECTOR    = 13'd512;
  localparam logic [7:0]  RST_SECTORS_PER_CLUSTER = 8'd1;
  localparam logic [15:0] RST_RESERVED_SECTORS    = 16'd1;
  localparam logic [7:0]  RST_FAT_COPIES          = 8'd2;
  localparam logic [15:0] RST_SECTORS_PER_FAT     = 16'd9;
  localparam logic [15:0] RST_ROOT_ENTRY_COUNT    = 16'd224;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_CHAIN = 2'd1,
    ST_LOW      = 2'd2
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_BYTES_PER_SECTOR    = 3'd0,
    CFG_SECTORS_PER_CLUSTER = 3'd1,
    CFG_RESERVED_SECTORS    = 3'd2,
    CFG_FAT_COPIES          = 3'd3,
    CFG_SECTORS_PER_FAT     = 3'd4,
    CFG_ROOT_ENTRY_COUNT    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_resp_t;

endpackage

>>> hw/rtl/fatcw_if.sv
`timescale 1ns / 1ps

interface fatcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [12:0] fat_address;
  logic [7:0]  fat_byte;
  logic [11:0] first_cluster;

  modport source (output valid, action, fat_address, fat_byte, first_cluster,
                  input ready);
  modport sink (input valid, action, fat_address, fat_byte, first_cluster,
                output ready);
endinterface

interface fatcw_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] sector_address;
  logic [11:0] cluster;
  logic [11:0] next_cluster;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, sector_address, cluster, next_cluster, last, status,
                  input ready);
  modport sink (input valid, sector_address, cluster, next_cluster, last, status,
                output ready);
endinterface

>>> hw/rtl/fatcw_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module fatcw_div (
  input  logic                clk,
  input  logic                rst_n,
  input  fatcw_pkg::div_req_t req,
  output fatcw_pkg::div_resp_t resp
);

  logic                                busy_r, busy_nxt;
  logic [fatcw_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [fatcw_pkg::DIV_DEN_W-1:0]     rem_r, rem_nxt;
  logic [fatcw_pkg::DIV_DEN_W-1:0]     den_r, den_nxt;
  logic [fatcw_pkg::DIV_NUM_W-1:0]     quo_r, quo_nxt;
  logic                                done_r, done_nxt;
  logic [fatcw_pkg::DIV_DEN_W:0]       rem_sh;
  logic                                fits;

  assign rem_sh = {rem_r, quo_r[fatcw_pkg::DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = fatcw_pkg::DIV_CNT_W'(fatcw_pkg::DIV_NUM_W - 1);
      rem_nxt  = '0;
      den_nxt  = req.den;
      quo_nxt  = req.num;
    end else if (busy_r) begin
      rem_nxt = fits ? fatcw_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_r})
                     : rem_sh[fatcw_pkg::DIV_DEN_W-1:0];
      quo_nxt = {quo_r[fatcw_pkg::DIV_NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign resp.done = done_r;
  assign resp.quot = quo_r;

endmodule

>>> hw/rtl/fat12_cluster_chain_walker.sv
`timescale 1ns / 1ps

// FAT12 cluster chain walker. A load item writes one byte of the 8 KiB FAT
// store. A start or step item returns one result: the FAT entry is read from
// the byte memory, which has one write and one read port, as two bytes, one
// per cycle, while the one shared 16x8 multiplier forms (cluster - 2) *
// sectors_per_cluster. Any configuration write, and reset, recompute the first
// data sector; the root directory sectors come from a one-bit-per-cycle
// divider, so ready stays low after reset and after the last configuration
// write until the divider is done. A finished result waits in the output
// register while the next item is taken.
module fat12_cluster_chain_walker (
  input  logic              clk,
  input  logic              rst_n,
  fatcw_in_if.sink          in_ch,
  fatcw_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_RD1   = 7'b0000100,
    S_RD2   = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_DMUL  = 7'b0100000,
    S_DDIV  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [12:0] bps_r;
  logic [7:0]  spc_r;
  logic [15:0] rsv_r;
  logic [7:0]  copies_r;
  logic [15:0] spf_r;
  logic [15:0] rec_r;

  logic        pend_r, pend_nxt;
  logic        active_r, active_nxt;
  logic [11:0] clus_r, clus_nxt;
  logic [24:0] ds_r, ds_nxt;
  logic [fatcw_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [7:0]  lo_r, lo_nxt;

  logic [24:0] res_sec_r, res_sec_nxt;
  logic [11:0] res_clus_r, res_clus_nxt;
  logic [11:0] res_next_r, res_next_nxt;
  logic        res_last_r, res_last_nxt;
  logic [1:0]  res_stat_r, res_stat_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [24:0] out_sec_r;
  logic [11:0] out_clus_r;
  logic [11:0] out_next_r;
  logic        out_last_r;
  logic [1:0]  out_stat_r;
  logic        out_load;

  logic [7:0]  fat_mem [fatcw_pkg::FAT_BYTES];
  logic [7:0]  rd_data_r;
  logic [fatcw_pkg::FAT_AW-1:0] rd_addr, idx_lo, idx_hi;
  logic        mem_we;

  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [fatcw_pkg::PROD_W-1:0] mul_p;

  logic [15:0] entry_word;
  logic [11:0] entry;
  logic        accept;

  fatcw_pkg::div_req_t  div_req;
  fatcw_pkg::div_resp_t div_resp;

  fatcw_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .resp (div_resp)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !pend_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // entry sits at byte cluster*3/2 of the store
  assign idx_lo = fatcw_pkg::FAT_AW'(clus_r) + fatcw_pkg::FAT_AW'(clus_r >> 1);
  assign idx_hi = idx_lo + 1'b1;
  assign rd_addr = (state_r == S_RD1) ? idx_hi : idx_lo;

  assign mem_we = accept && (in_ch.action == fatcw_pkg::ACT_LOAD) &&
                  (int'(in_ch.fat_address) < fatcw_pkg::FAT_BYTES);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fat_mem[fatcw_pkg::FAT_AW'(in_ch.fat_address)] <= in_ch.fat_byte;
    end
    rd_data_r <= fat_mem[rd_addr];
  end

  // shared multiplier: fat size during derivation, cluster offset on a walk
  always_comb begin
    if (state_r == S_DMUL) begin
      mul_a = spf_r;
      mul_b = copies_r;
    end else begin
      mul_a = 16'(clus_r - fatcw_pkg::FIRST_DATA_CLUSTER);
      mul_b = spc_r;
    end
  end
  assign mul_p = fatcw_pkg::PROD_W'(mul_a) * fatcw_pkg::PROD_W'(mul_b);

  assign entry_word = {rd_data_r, lo_r};
  assign entry      = clus_r[0] ? entry_word[15:4] : entry_word[11:0];

  always_comb begin
    div_req.start = (state_r == S_DMUL);
    div_req.num   = fatcw_pkg::DIV_NUM_W'({rec_r, 5'b0}) +
                    fatcw_pkg::DIV_NUM_W'(bps_r) - 1'b1;
    div_req.den   = bps_r;
  end

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    pend_nxt     = pend_r;
    active_nxt   = active_r;
    clus_nxt     = clus_r;
    ds_nxt       = ds_r;
    prod_nxt     = prod_r;
    lo_nxt       = lo_r;
    res_sec_nxt  = res_sec_r;
    res_clus_nxt = res_clus_r;
    res_next_nxt = res_next_r;
    res_last_nxt = res_last_r;
    res_stat_nxt = res_stat_r;

    unique case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          state_nxt = S_DMUL;
        end else if (accept) begin
          case (in_ch.action)
            fatcw_pkg::ACT_START: begin
              clus_nxt   = in_ch.first_cluster;
              active_nxt = 1'b1;
              state_nxt  = S_CHECK;
            end
            fatcw_pkg::ACT_STEP: begin
              if (active_r) begin
                state_nxt = S_CHECK;
              end else begin
                res_sec_nxt  = '0;
                res_clus_nxt = '0;
                res_next_nxt = '0;
                res_last_nxt = 1'b0;
                res_stat_nxt = fatcw_pkg::ST_NO_CHAIN;
                state_nxt    = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (clus_r < fatcw_pkg::FIRST_DATA_CLUSTER) begin
          active_nxt   = 1'b0;
          res_sec_nxt  = '0;
          res_clus_nxt = clus_r;
          res_next_nxt = '0;
          res_last_nxt = 1'b1;
          res_stat_nxt = fatcw_pkg::ST_LOW;
          state_nxt    = S_EMIT;
        end else begin
          prod_nxt  = mul_p;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        lo_nxt    = rd_data_r;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        res_sec_nxt  = 25'(ds_r + 25'(prod_r));
        res_clus_nxt = clus_r;
        res_next_nxt = entry;
        res_last_nxt = entry >= fatcw_pkg::CHAIN_END;
        res_stat_nxt = fatcw_pkg::ST_OK;
        clus_nxt     = entry;
        active_nxt   = entry < fatcw_pkg::CHAIN_END;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      S_DMUL: begin
        prod_nxt  = mul_p;
        pend_nxt  = 1'b0;
        state_nxt = S_DDIV;
      end
      S_DDIV: begin
        if (div_resp.done) begin
          ds_nxt = 25'(25'(rsv_r) + 25'(prod_r) +
                       ((bps_r == '0) ? 25'd0 : 25'(div_resp.quot)));
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      pend_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b1;
      active_r    <= 1'b0;
      clus_r      <= '0;
      ds_r        <= '0;
      out_valid_r <= 1'b0;
      bps_r       <= fatcw_pkg::RST_BYTES_PER_SECTOR;
      spc_r       <= fatcw_pkg::RST_SECTORS_PER_CLUSTER;
      rsv_r       <= fatcw_pkg::RST_RESERVED_SECTORS;
      copies_r    <= fatcw_pkg::RST_FAT_COPIES;
      spf_r       <= fatcw_pkg::RST_SECTORS_PER_FAT;
      rec_r       <= fatcw_pkg::RST_ROOT_ENTRY_COUNT;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      active_r    <= active_nxt;
      clus_r      <= clus_nxt;
      ds_r        <= ds_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          fatcw_pkg::CFG_BYTES_PER_SECTOR:    bps_r    <= cfg_data[12:0];
          fatcw_pkg::CFG_SECTORS_PER_CLUSTER: spc_r    <= cfg_data[7:0];
          fatcw_pkg::CFG_RESERVED_SECTORS:    rsv_r    <= cfg_data;
          fatcw_pkg::CFG_FAT_COPIES:          copies_r <= cfg_data[7:0];
          fatcw_pkg::CFG_SECTORS_PER_FAT:     spf_r    <= cfg_data;
          fatcw_pkg::CFG_ROOT_ENTRY_COUNT:    rec_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    lo_r       <= lo_nxt;
    res_sec_r  <= res_sec_nxt;
    res_clus_r <= res_clus_nxt;
    res_next_r <= res_next_nxt;
    res_last_r <= res_last_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_sec_r  <= res_sec_r;
      out_clus_r <= res_clus_r;
      out_next_r <= res_next_r;
      out_last_r <= res_last_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sector_address = out_sec_r;
  assign out_ch.cluster        = out_clus_r;
  assign out_ch.next_cluster   = out_next_r;
  assign out_ch.last           = out_last_r;
  assign out_ch.status         = out_stat_r;

endmodule

>>> test/fat12_cluster_chain_walker_tb.sv
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 12;
  localparam int PHASE_ITEMS  = 80;
  localparam int N_DIRECTED   = 25;

  typedef struct packed {
    fatcw_pkg::action_t action;
    logic [12:0] fat_address;
    logic [7:0]  fat_byte;
    logic [11:0] first_cluster;
  } walk_item_t;

  typedef struct packed {
    logic [24:0] sector_address;
    logic [11:0] cluster;
    logic [11:0] next_cluster;
    logic        last;
    fatcw_pkg::status_t status;
  } sector_report_t;

  typedef struct packed {
    walk_item_t     item;
    logic           known;
    sector_report_t report;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  fatcw_in_if  in_ch ();
  fatcw_out_if out_ch ();

  fat12_cluster_chain_walker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block
  logic [7:0]  fat_img    [fatcw_pkg::FAT_BYTES];
  bit          fat_loaded [fatcw_pkg::FAT_BYTES];
  logic [11:0] walk_cluster;
  bit          walk_active;
  int unsigned bps_r, spc_r, res_r, copies_r, spf_r, rec_r;
  logic [24:0] data_start;

  sector_report_t sector_reports [$];
  sector_report_t monitor_want;
  int errors;
  int cycles;
  int burst_left;
  int phase_items;
  directed_row_t directed_rows [N_DIRECTED];

  function automatic logic [24:0] first_data_sector();
    int unsigned root_secs;
    int unsigned total;
    root_secs = 0;
    if (bps_r != 0) begin
      root_secs = (rec_r * 32 + bps_r - 1) / bps_r;
    end
    total = res_r + copies_r * spf_r + root_secs;
    return total[24:0];
  endfunction

  function automatic logic [11:0] fat_entry_of(logic [11:0] clus);
    int unsigned idx;
    logic [15:0] w;
    idx = (int'(clus) * 3) / 2;
    w = {fat_img[fatcw_pkg::FAT_AW'(idx + 1)], fat_img[fatcw_pkg::FAT_AW'(idx)]};
    if (clus[0] == 1'b0) begin
      return w[11:0];
    end
    return w[15:4];
  endfunction

  task automatic follow_cluster(input walk_item_t it, output bit produced,
                                output sector_report_t rep);
    logic [11:0] clus;
    logic [11:0] nxt;
    int unsigned sec;
    produced = 1'b0;
    rep = '0;
    case (it.action)
      fatcw_pkg::ACT_LOAD: begin
        fat_img[it.fat_address] = it.fat_byte;
        fat_loaded[it.fat_address] = 1'b1;
        return;
      end
      fatcw_pkg::ACT_START: begin
        walk_cluster = it.first_cluster;
        walk_active = 1'b1;
      end
      fatcw_pkg::ACT_STEP: begin
        if (!walk_active) begin
          produced = 1'b1;
          rep.status = fatcw_pkg::ST_NO_CHAIN;
          return;
        end
      end
      default: return;
    endcase
    produced = 1'b1;
    clus = walk_cluster;
    if (clus < fatcw_pkg::FIRST_DATA_CLUSTER) begin
      walk_active = 1'b0;
      rep.cluster = clus;
      rep.last = 1'b1;
      rep.status = fatcw_pkg::ST_LOW;
      return;
    end
    sec = 32'(data_start) + (int'(clus) - 2) * spc_r;
    nxt = fat_entry_of(clus);
    rep.sector_address = sec[24:0];
    rep.cluster = clus;
    rep.next_cluster = nxt;
    rep.last = (nxt >= fatcw_pkg::CHAIN_END);
    rep.status = fatcw_pkg::ST_OK;
    walk_cluster = nxt;
    walk_active = !rep.last;
  endtask

  // drop valid and hold off until every pending report is back
  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sector_reports.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input walk_item_t it, input bit known,
                           input sector_report_t known_rep);
    bit produced;
    sector_report_t rep;
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.action        <= it.action;
    in_ch.fat_address   <= it.fat_address;
    in_ch.fat_byte      <= it.fat_byte;
    in_ch.first_cluster <= it.first_cluster;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    follow_cluster(it, produced, rep);
    if (produced) begin
      sector_reports.push_back(known ? known_rep : rep);
    end
    if (it.action != fatcw_pkg::ACT_NONE) phase_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 29) == 0) begin
        drain_reports();
      end else if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_byte(input int addr, input logic [7:0] value);
    walk_item_t it;
    it = '0;
    it.action = fatcw_pkg::ACT_LOAD;
    it.fat_address = addr[12:0];
    it.fat_byte = value;
    it.first_cluster = 12'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // never let the block read a FAT byte that was not loaded
  task automatic ensure_entry(input logic [11:0] clus);
    int unsigned idx;
    int unsigned a;
    if (clus < fatcw_pkg::FIRST_DATA_CLUSTER) return;
    idx = (int'(clus) * 3) / 2;
    for (int k = 0; k < 2; k++) begin
      a = (idx + k) % fatcw_pkg::FAT_BYTES;
      if (!fat_loaded[fatcw_pkg::FAT_AW'(a)]) load_byte(a, 8'($urandom));
    end
  endtask

  task automatic issue(input walk_item_t it, input bit known,
                       input sector_report_t known_rep);
    if (it.action == fatcw_pkg::ACT_START) ensure_entry(it.first_cluster);
    if (it.action == fatcw_pkg::ACT_STEP && walk_active) ensure_entry(walk_cluster);
    send_item(it, known, known_rep);
  endtask

  task automatic issue_walk(input fatcw_pkg::action_t act, input logic [11:0] clus);
    walk_item_t it;
    it.action = act;
    it.fat_address = 13'($urandom);
    it.fat_byte = 8'($urandom);
    it.first_cluster = clus;
    issue(it, 1'b0, '0);
  endtask

  // read-modify-write of the two bytes that hold one packed entry
  task automatic set_entry(input logic [11:0] clus, input logic [11:0] value);
    int unsigned idx;
    logic [7:0] b0, b1;
    idx = (int'(clus) * 3) / 2;
    if (clus[0] == 1'b0) begin
      b0 = value[7:0];
      b1 = {fat_img[fatcw_pkg::FAT_AW'(idx + 1)][7:4], value[11:8]};
    end else begin
      b0 = {value[3:0], fat_img[fatcw_pkg::FAT_AW'(idx)][3:0]};
      b1 = value[11:4];
    end
    load_byte(idx, b0);
    load_byte(idx + 1, b1);
  endtask

  task automatic random_chain();
    logic [11:0] links [8];
    int n;
    int r;
    logic [11:0] tail;
    n = $urandom_range(1, 6);
    links[0] = 12'($urandom_range(2, 4095));
    for (int i = 1; i <= n; i++) begin
      if ($urandom_range(0, 1) == 1 && links[i-1] != 12'hFFF) begin
        links[i] = links[i-1] + 12'd1;
      end else begin
        links[i] = 12'($urandom_range(2, 4095));
      end
    end
    r = $urandom_range(0, 9);
    if (r < 8) begin
      tail = fatcw_pkg::CHAIN_END + 12'($urandom_range(0, 7));
    end else if (r == 8) begin
      tail = 12'($urandom_range(0, 1));
    end else begin
      tail = 12'($urandom);
    end
    for (int i = 0; i < n; i++) set_entry(links[i], links[i+1]);
    set_entry(links[n], tail);
    issue_walk(fatcw_pkg::ACT_START, links[0]);
    for (int i = 0; i < n + $urandom_range(0, 1); i++) begin
      issue_walk(fatcw_pkg::ACT_STEP, 12'($urandom));
    end
  endtask

  task automatic random_phase();
    int r;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        random_chain();
      end else if (r < 70) begin
        load_byte($urandom_range(0, fatcw_pkg::FAT_BYTES - 1), 8'($urandom));
      end else if (r < 80) begin
        issue_walk(fatcw_pkg::ACT_START, 12'($urandom));
      end else if (r < 93) begin
        issue_walk(fatcw_pkg::ACT_STEP, 12'($urandom));
      end else begin
        issue_walk(fatcw_pkg::ACT_NONE, 12'($urandom));
      end
    end
  endtask

  task automatic write_reg(input fatcw_pkg::cfg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      fatcw_pkg::CFG_BYTES_PER_SECTOR:    bps_r    = 32'(value[12:0]);
      fatcw_pkg::CFG_SECTORS_PER_CLUSTER: spc_r    = 32'(value[7:0]);
      fatcw_pkg::CFG_RESERVED_SECTORS:    res_r    = 32'(value);
      fatcw_pkg::CFG_FAT_COPIES:          copies_r = 32'(value[7:0]);
      fatcw_pkg::CFG_SECTORS_PER_FAT:     spf_r    = 32'(value);
      fatcw_pkg::CFG_ROOT_ENTRY_COUNT:    rec_r    = 32'(value);
      default: ;
    endcase
    data_start = first_data_sector();
  endtask

  function automatic directed_row_t plain(fatcw_pkg::action_t a, int addr, int value,
                                          int clus);
    directed_row_t d;
    d = '0;
    d.item.action = a;
    d.item.fat_address = addr[12:0];
    d.item.fat_byte = value[7:0];
    d.item.first_cluster = clus[11:0];
    return d;
  endfunction

  function automatic directed_row_t known(fatcw_pkg::action_t a, int clus, int sec,
                                          int rclus, int nxt, bit lst,
                                          fatcw_pkg::status_t st);
    directed_row_t d;
    d = plain(a, 0, 0, clus);
    d.known = 1'b1;
    d.report.sector_address = sec[24:0];
    d.report.cluster = rclus[11:0];
    d.report.next_cluster = nxt[11:0];
    d.report.last = lst;
    d.report.status = st;
    return d;
  endfunction

  // receiver stall pattern in one of four randomly chosen modes
  initial begin
    int rx_tick;
    int rx_mode;
    rx_tick = 0;
    rx_mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (rx_tick % 8 == 0);
        default: out_ch.ready <= ((rx_tick >> 2) & 1) == 1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (sector_reports.size() == 0) begin
        $error("report with no item pending: cluster %0h status %0d",
               out_ch.cluster, out_ch.status);
        errors++;
      end else begin
        monitor_want = sector_reports.pop_front();
        if (out_ch.sector_address !== monitor_want.sector_address) begin
          $error("sector_address: expected %0h, got %0h",
                 monitor_want.sector_address, out_ch.sector_address);
          errors++;
        end
        if (out_ch.cluster !== monitor_want.cluster) begin
          $error("cluster: expected %0h, got %0h", monitor_want.cluster, out_ch.cluster);
          errors++;
        end
        if (out_ch.next_cluster !== monitor_want.next_cluster) begin
          $error("next_cluster: expected %0h, got %0h",
                 monitor_want.next_cluster, out_ch.next_cluster);
          errors++;
        end
        if (out_ch.last !== monitor_want.last) begin
          $error("last: expected %0b, got %0b", monitor_want.last, out_ch.last);
          errors++;
        end
        if (out_ch.status !== monitor_want.status) begin
          $error("status: expected %0d, got %0d", monitor_want.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] geometry [6][6];
    fatcw_pkg::cfg_idx_t reg_order [6];
    errors = 0;
    cycles = 0;
    burst_left = 1;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= fatcw_pkg::CFG_BYTES_PER_SECTOR;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= fatcw_pkg::ACT_NONE;
    in_ch.fat_address   <= '0;
    in_ch.fat_byte      <= '0;
    in_ch.first_cluster <= '0;
    for (int i = 0; i < fatcw_pkg::FAT_BYTES; i++) begin
      fat_img[i] = '0;
      fat_loaded[i] = 1'b0;
    end
    walk_cluster = '0;
    walk_active = 1'b0;
    bps_r = 32'(fatcw_pkg::RST_BYTES_PER_SECTOR);
    spc_r = 32'(fatcw_pkg::RST_SECTORS_PER_CLUSTER);
    res_r = 32'(fatcw_pkg::RST_RESERVED_SECTORS);
    copies_r = 32'(fatcw_pkg::RST_FAT_COPIES);
    spf_r = 32'(fatcw_pkg::RST_SECTORS_PER_FAT);
    rec_r = 32'(fatcw_pkg::RST_ROOT_ENTRY_COUNT);
    data_start = first_data_sector();

    reg_order = '{fatcw_pkg::CFG_BYTES_PER_SECTOR, fatcw_pkg::CFG_SECTORS_PER_CLUSTER,
                  fatcw_pkg::CFG_RESERVED_SECTORS, fatcw_pkg::CFG_FAT_COPIES,
                  fatcw_pkg::CFG_SECTORS_PER_FAT, fatcw_pkg::CFG_ROOT_ENTRY_COUNT};
    geometry = '{
      '{16'd32,   16'd1,   16'd0,     16'd1,   16'd1,     16'd0},
      '{16'd8191, 16'd255, 16'd65535, 16'd255, 16'd65535, 16'd65535},
      '{16'd0,    16'd4,   16'd100,   16'd2,   16'd9,     16'd512},
      '{16'd512,  16'd0,   16'd32,    16'd2,   16'd3000,  16'd224},
      '{16'd4096, 16'd128, 16'd65535, 16'd255, 16'd65535, 16'd65535},
      '{16'd512,  16'd1,   16'd1,     16'd2,   16'd9,     16'd224}
    };

    // data start is 33 sectors with the reset geometry
    directed_rows[0]  = known(fatcw_pkg::ACT_STEP, 0, 0, 0, 0, 1'b0, fatcw_pkg::ST_NO_CHAIN);
    directed_rows[1]  = plain(fatcw_pkg::ACT_NONE, 8191, 255, 4095);
    directed_rows[2]  = known(fatcw_pkg::ACT_START, 0, 0, 0, 0, 1'b1, fatcw_pkg::ST_LOW);
    directed_rows[3]  = known(fatcw_pkg::ACT_STEP, 0, 0, 0, 0, 1'b0, fatcw_pkg::ST_NO_CHAIN);
    directed_rows[4]  = known(fatcw_pkg::ACT_START, 1, 0, 1, 0, 1'b1, fatcw_pkg::ST_LOW);
    directed_rows[5]  = plain(fatcw_pkg::ACT_LOAD, 3, 8'hFF, 0);
    directed_rows[6]  = plain(fatcw_pkg::ACT_LOAD, 4, 8'h8F, 0);
    directed_rows[7]  = plain(fatcw_pkg::ACT_LOAD, 5, 8'hFF, 0);
    directed_rows[8]  = known(fatcw_pkg::ACT_START, 2, 33, 2, 12'hFFF, 1'b1, fatcw_pkg::ST_OK);
    directed_rows[9]  = known(fatcw_pkg::ACT_STEP, 0, 0, 0, 0, 1'b0, fatcw_pkg::ST_NO_CHAIN);
    directed_rows[10] = plain(fatcw_pkg::ACT_LOAD, 0, 8'h00, 0);
    directed_rows[11] = plain(fatcw_pkg::ACT_LOAD, 8191, 8'hFF, 0);
    directed_rows[12] = plain(fatcw_pkg::ACT_LOAD, 6142, 8'h30, 0);
    directed_rows[13] = plain(fatcw_pkg::ACT_LOAD, 6143, 8'h00, 0);
    directed_rows[14] = plain(fatcw_pkg::ACT_START, 0, 0, 4095);
    directed_rows[15] = plain(fatcw_pkg::ACT_STEP, 0, 0, 0);
    directed_rows[16] = known(fatcw_pkg::ACT_STEP, 0, 0, 0, 0, 1'b0, fatcw_pkg::ST_NO_CHAIN);
    directed_rows[17] = plain(fatcw_pkg::ACT_LOAD, 6141, 8'h01, 0);
    directed_rows[18] = plain(fatcw_pkg::ACT_START, 0, 0, 4094);
    // entry of 4094 points at cluster 1, which is below the data area
    directed_rows[19] = known(fatcw_pkg::ACT_STEP, 0, 0, 1, 0, 1'b1, fatcw_pkg::ST_LOW);
    directed_rows[20] = known(fatcw_pkg::ACT_STEP, 0, 0, 0, 0, 1'b0, fatcw_pkg::ST_NO_CHAIN);
    directed_rows[21] = plain(fatcw_pkg::ACT_NONE, 0, 0, 0);
    directed_rows[22] = plain(fatcw_pkg::ACT_START, 0, 0, 4095);
    // restart in the middle of a chain
    directed_rows[23] = known(fatcw_pkg::ACT_START, 2, 33, 2, 12'hFFF, 1'b1, fatcw_pkg::ST_OK);
    directed_rows[24] = known(fatcw_pkg::ACT_STEP, 0, 0, 0, 0, 1'b0, fatcw_pkg::ST_NO_CHAIN);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      issue(directed_rows[i].item, directed_rows[i].known, directed_rows[i].report);
    end
    random_phase();

    for (int p = 0; p < 6; p++) begin
      drain_reports();
      repeat (SETTLE) @(posedge clk);
      if (p == 5) begin
        geometry[5][0] = 16'($urandom_range(32, 4096));
        geometry[5][1] = 16'($urandom_range(1, 128));
        geometry[5][2] = 16'($urandom);
        geometry[5][3] = 16'($urandom_range(1, 255));
        geometry[5][4] = 16'($urandom_range(1, 65535));
        geometry[5][5] = 16'($urandom);
      end
      for (int r = 0; r < 6; r++) write_reg(reg_order[r], geometry[p][r]);
      cfg_we <= 1'b0;
      random_phase();
    end

    drain_reports();
    repeat (SETTLE * 2) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
